// File: rtl/plm_pkg.sv
// Package for the positional list engine.
// Holds the request and response types, the command, status and cell codes.
// Depends on nothing.
package plm_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 7;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_READ_OUT  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } t_cell_op;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_req;

    typedef struct packed {
        logic signed [31:0] element;
        logic               element_valid;
        t_status            status;
        logic [4:0]         count;
        logic               last;
    } t_rsp;

    typedef struct packed {
        t_cell_op          op;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  last_idx;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

// File: rtl/plm_cell.sv
// One storage cell of the list chain, holding the entry at a fixed position.
// Depends on plm_pkg for the broadcast control struct.
module plm_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic                            i_clk,
    input  plm_pkg::t_cell_ctl              i_ctl,
    input  logic [plm_pkg::DATA_W-1:0]      i_left,
    input  logic [plm_pkg::DATA_W-1:0]      i_right,
    input  logic [plm_pkg::DATA_W-1:0]      i_head,
    output logic [plm_pkg::DATA_W-1:0]      o_data
);

    localparam logic [plm_pkg::IDX_W-1:0] K = plm_pkg::IDX_W'(CELL_IDX);

    logic [plm_pkg::DATA_W-1:0] r_data;
    logic [plm_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            plm_pkg::OP_INSERT: begin
                if (K > i_ctl.idx) begin
                    n_data = i_left;
                end else if (K == i_ctl.idx) begin
                    n_data = i_ctl.value;
                end
            end
            plm_pkg::OP_DELETE: begin
                if (K >= i_ctl.idx) begin
                    n_data = i_right;
                end
            end
            plm_pkg::OP_ROTATE: begin
                if (K < i_ctl.last_idx) begin
                    n_data = i_right;
                end else if (K == i_ctl.last_idx) begin
                    n_data = i_head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/positional_list_engine_top.sv
// Top level of the positional list engine: command decode, length, read sequencer.
// Depends on plm_pkg and plm_cell.
//
//   channel   direction   handshake                    payload
//   request   in          i_req_valid / o_req_ready    i_req  (plm_pkg::t_req)
//   response  out         o_rsp_valid / i_rsp_ready    o_rsp  (plm_pkg::t_rsp)
//
// Inserts, deletes and rejected commands give one response each.
// A read of N entries first starts the sequencer, then the head cell is sent each cycle
// that the response slot is free while the cell chain rotates by one, so after N steps
// the list is back in place.
// Reset clears the length and the sequencer; no clearing pass is needed.
// A stalled response holds its register and blocks the next request or step.
module positional_list_engine_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  plm_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output plm_pkg::t_rsp o_rsp
);

    localparam int unsigned LEN_W = $clog2(CAPACITY + 1);

    plm_pkg::t_state    r_state;
    plm_pkg::t_state    n_state;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   n_len;
    logic [LEN_W-1:0]   r_cnt;
    logic [LEN_W-1:0]   n_cnt;
    logic               r_rsp_valid;
    logic               n_rsp_valid;
    plm_pkg::t_rsp      r_rsp;
    plm_pkg::t_rsp      n_rsp;
    plm_pkg::t_cell_ctl w_ctl;
    plm_pkg::t_status   w_status;
    logic               w_load;
    logic               w_slot;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_read_last;
    logic [8:0]         w_pos;
    logic [8:0]         w_len9;
    logic [plm_pkg::DATA_W-1:0] w_cell_data [CAPACITY];

    assign w_slot      = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == plm_pkg::S_IDLE) && w_slot;
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_full      = (r_len == LEN_W'(CAPACITY));
    assign w_empty     = (r_len == '0);
    assign w_pos       = 9'(i_req.position);
    assign w_len9      = 9'(r_len);
    assign w_read_last = (r_cnt == LEN_W'(r_len - 1'b1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            plm_pkg::S_IDLE: begin
                if (w_accept && (i_req.command == plm_pkg::CMD_READ_OUT) && !w_empty) begin
                    n_state = plm_pkg::S_READ;
                end
            end
            plm_pkg::S_READ: begin
                if (w_slot && w_read_last) begin
                    n_state = plm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = plm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_len          = r_len;
        n_cnt          = r_cnt;
        n_rsp          = r_rsp;
        w_load         = 1'b0;
        w_status       = plm_pkg::ST_OK;
        w_ctl.op       = plm_pkg::OP_HOLD;
        w_ctl.idx      = '0;
        w_ctl.last_idx = plm_pkg::IDX_W'(r_len - 1'b1);
        w_ctl.value    = $unsigned(i_req.value);
        case (r_state)
            plm_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_load = 1'b1;
                    case (i_req.command)
                        plm_pkg::CMD_INS_FRONT, plm_pkg::CMD_INS_BACK: begin
                            if (w_full) begin
                                w_status = plm_pkg::ST_FULL;
                            end else begin
                                w_ctl.op  = plm_pkg::OP_INSERT;
                                w_ctl.idx = (i_req.command == plm_pkg::CMD_INS_FRONT) ?
                                            '0 : plm_pkg::IDX_W'(r_len);
                                n_len     = LEN_W'(r_len + 1'b1);
                            end
                        end
                        plm_pkg::CMD_INS_AT: begin
                            if ((w_pos == '0) || (w_pos > (w_len9 + 9'd1))) begin
                                w_status = plm_pkg::ST_BADPOS;
                            end else if (w_full) begin
                                w_status = plm_pkg::ST_FULL;
                            end else begin
                                w_ctl.op  = plm_pkg::OP_INSERT;
                                w_ctl.idx = plm_pkg::IDX_W'(w_pos - 9'd1);
                                n_len     = LEN_W'(r_len + 1'b1);
                            end
                        end
                        plm_pkg::CMD_DEL_FRONT, plm_pkg::CMD_DEL_BACK: begin
                            if (w_empty) begin
                                w_status = plm_pkg::ST_EMPTY;
                            end else begin
                                w_ctl.op  = plm_pkg::OP_DELETE;
                                w_ctl.idx = (i_req.command == plm_pkg::CMD_DEL_FRONT) ?
                                            '0 : plm_pkg::IDX_W'(r_len - 1'b1);
                                n_len     = LEN_W'(r_len - 1'b1);
                            end
                        end
                        plm_pkg::CMD_DEL_AT: begin
                            if ((w_pos == '0) || (w_pos > w_len9)) begin
                                w_status = plm_pkg::ST_BADPOS;
                            end else begin
                                w_ctl.op  = plm_pkg::OP_DELETE;
                                w_ctl.idx = plm_pkg::IDX_W'(w_pos - 9'd1);
                                n_len     = LEN_W'(r_len - 1'b1);
                            end
                        end
                        plm_pkg::CMD_READ_OUT: begin
                            if (!w_empty) begin
                                w_load = 1'b0;
                                n_cnt  = '0;
                            end
                        end
                        default: begin
                            w_status = plm_pkg::ST_OK;
                        end
                    endcase
                    n_rsp.element       = '0;
                    n_rsp.element_valid = 1'b0;
                    n_rsp.status        = w_status;
                    n_rsp.count         = 5'(n_len);
                    n_rsp.last          = 1'b1;
                end
            end
            plm_pkg::S_READ: begin
                if (w_slot) begin
                    w_ctl.op            = plm_pkg::OP_ROTATE;
                    w_load              = 1'b1;
                    n_cnt               = LEN_W'(r_cnt + 1'b1);
                    n_rsp.element       = $signed(w_cell_data[0]);
                    n_rsp.element_valid = 1'b1;
                    n_rsp.status        = plm_pkg::ST_OK;
                    n_rsp.count         = 5'(r_len);
                    n_rsp.last          = w_read_last;
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
        if (w_load) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plm_pkg::S_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rsp <= n_rsp;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [plm_pkg::DATA_W-1:0] w_left;
        logic [plm_pkg::DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end
        plm_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_left (w_left),
            .i_right(w_right),
            .i_head (w_cell_data[0]),
            .o_data (w_cell_data[g])
        );
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("list length exceeds capacity");

    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plm_pkg::S_READ) |-> (!o_req_ready && (r_cnt < r_len)))
        else $error("read sequencer out of range or taking requests");

    a_single_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.command != plm_pkg::CMD_READ_OUT)) |=>
        (o_rsp_valid && o_rsp.last && !o_rsp.element_valid))
        else $error("single response missing after command");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.element_valid) |-> (o_rsp.status == plm_pkg::ST_OK))
        else $error("read-out entry with error status");

endmodule
